[design/psu_pkg.sv]
// ============================================================================
// psu_pkg - PNG scanline unfilter shared types and constants
// Byte and configuration types, register indexes, filter codes and the
// internal item kinds passed down the pipeline.
// ============================================================================
package psu_pkg;

    typedef logic [7:0] byte_t;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_ROW_BYTES   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_PIXEL_BYTES = cfg_idx_t'(1);

    localparam int ROW_BYTES_W   = 13;
    localparam int PIXEL_BYTES_W = 4;
    localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RST   = 13'd1;
    localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = 4'd1;

    // filter type codes
    typedef logic [2:0] filt_t;
    localparam filt_t FILT_NONE  = 3'd0;
    localparam filt_t FILT_SUB   = 3'd1;
    localparam filt_t FILT_UP    = 3'd2;
    localparam filt_t FILT_AVG   = 3'd3;
    localparam filt_t FILT_PAETH = 3'd4;

    // item kinds between the front stage and the reconstruction stage
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DROP = 2'd0;
    localparam kind_t KIND_FILT = 2'd1;
    localparam kind_t KIND_ERR  = 2'd2;
    localparam kind_t KIND_DATA = 2'd3;

endpackage

[design/psu_if.sv]
// ============================================================================
// psu_if - PNG scanline unfilter channel interfaces
// Valid/ready channels for filtered input bytes, reconstructed output bytes
// and configuration writes.
// ============================================================================
interface psu_in_if;
    logic             valid;
    logic             ready;
    psu_pkg::byte_t   raw_byte;
    logic             image_start;

    modport source (output valid, output raw_byte, output image_start, input ready);
    modport sink   (input valid, input raw_byte, input image_start, output ready);
endinterface

interface psu_out_if;
    logic             valid;
    logic             ready;
    psu_pkg::byte_t   pixel_byte;
    logic             row_end;
    logic             bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_end, input bad_filter,
                    output ready);
endinterface

interface psu_cfg_if;
    logic                valid;
    logic                ready;
    psu_pkg::cfg_idx_t   index;
    psu_pkg::cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/psu_ram.sv]
// ============================================================================
// psu_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/png_scanline_unfilter.sv]
// ============================================================================
// png_scanline_unfilter - PNG filter reconstruction (None/Sub/Up/Avg/Paeth)
// Rebuilds scanline bytes from a filtered stream, keeping the prior row in a
// line buffer RAM and the last pixel of both rows in short shift histories.
// ============================================================================
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  cfg     | in  | valid/ready   | index, data (row_bytes, pixel_bytes)
//  src     | in  | valid/ready   | raw_byte, image_start
//  dst     | out | valid/ready   | pixel_byte, row_end, bad_filter
//
//  One item per cycle sustained while dst is ready. An item is decoded and its
//  line buffer read issued on acceptance, reconstructed from the stage 1
//  registers, and its result registered in the output register behind dst.valid.
//  Left-neighbor feedback runs through one register stage, so that loop sets
//  the clock, not the rate. Reset clears control state; the line buffer
//  needs no clearing. A stalled dst holds the pipeline; src keeps flowing
//  into empty stages.
// ============================================================================
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    psu_cfg_if.sink   cfg,
    psu_in_if.sink    src,
    psu_out_if.source dst
);

    import psu_pkg::*;

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int LW = (CW > ROW_BYTES_W) ? CW : ROW_BYTES_W;
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int RAM_DEPTH = 1 << AW;

    // configuration registers
    logic [ROW_BYTES_W-1:0]   row_bytes_reg;
    logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg;

    // front stage state
    logic [CW-1:0] col_reg;
    logic          failed_reg;
    logic          prior_reg;
    filt_t         filt_reg;

    // reconstruction stage registers
    logic          s1_valid_reg;
    kind_t         s1_kind_reg;
    filt_t         s1_filt_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          s1_last_reg;
    logic          s1_prior_reg;
    byte_t         s1_raw_reg;
    logic          byp_hit_reg;
    byte_t         byp_data_reg;

    // histories, newest first
    byte_t left_hist_reg [MAX_PIXEL_BYTES];
    byte_t ul_hist_reg   [MAX_PIXEL_BYTES];

    // output register
    logic  out_valid_reg;
    byte_t out_pixel_reg;
    logic  out_row_end_reg;
    logic  out_bad_reg;

    // ------------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= ROW_BYTES_RST;
            pixel_bytes_reg <= PIXEL_BYTES_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROW_BYTES:   row_bytes_reg   <= cfg.data[ROW_BYTES_W-1:0];
                REG_PIXEL_BYTES: pixel_bytes_reg <= cfg.data[PIXEL_BYTES_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective row length and pixel size
    logic [LW-1:0]            len_ext;
    logic [LW-1:0]            len_eff;
    logic [PIXEL_BYTES_W-1:0] pb_eff;
    logic [PW-1:0]            pb_idx;

    always_comb
    begin
        len_ext = LW'(row_bytes_reg);
        if (len_ext == '0)
            len_eff = LW'(1);
        else if (len_ext > LW'(MAX_ROW_BYTES))
            len_eff = LW'(MAX_ROW_BYTES);
        else
            len_eff = len_ext;

        if (pixel_bytes_reg == '0)
            pb_eff = PIXEL_BYTES_W'(1);
        else if (pixel_bytes_reg > PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
            pb_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
        else
            pb_eff = pixel_bytes_reg;
        pb_idx = PW'(pb_eff - PIXEL_BYTES_W'(1));
    end

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    logic advance;
    logic s1_move;
    logic accept;

    assign advance   = !out_valid_reg || dst.ready;
    assign s1_move   = s1_valid_reg && advance;
    assign src.ready = !s1_valid_reg || advance;
    assign accept    = src.valid && src.ready;

    // ------------------------------------------------------------------------
    // front stage: column tracking and item decode
    // ------------------------------------------------------------------------
    logic [CW-1:0] col_cur;
    logic          failed_cur;
    logic          prior_cur;
    kind_t         kind_d;
    logic [AW-1:0] idx_d;
    logic          last_d;
    logic [CW-1:0] col_next;
    logic          failed_next;
    logic          prior_next;
    filt_t         filt_next;

    always_comb
    begin
        col_cur    = src.image_start ? '0   : col_reg;
        failed_cur = src.image_start ? 1'b0 : failed_reg;
        prior_cur  = src.image_start ? 1'b0 : prior_reg;

        col_next    = col_cur;
        failed_next = failed_cur;
        prior_next  = prior_cur;
        filt_next   = filt_reg;
        idx_d       = AW'(col_cur - CW'(1));
        last_d      = (LW'(col_cur) >= len_eff);

        if (failed_cur)
        begin
            kind_d = KIND_DROP;
        end
        else if (col_cur == '0)
        begin
            if (src.raw_byte > byte_t'(FILT_PAETH))
            begin
                kind_d      = KIND_ERR;
                failed_next = 1'b1;
            end
            else
            begin
                kind_d    = KIND_FILT;
                filt_next = src.raw_byte[2:0];
                col_next  = CW'(1);
            end
        end
        else
        begin
            kind_d = KIND_DATA;
            if (last_d)
            begin
                col_next   = '0;
                prior_next = 1'b1;
            end
            else
            begin
                col_next = col_cur + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            failed_reg <= 1'b0;
            prior_reg  <= 1'b0;
            filt_reg   <= FILT_NONE;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            failed_reg <= failed_next;
            prior_reg  <= prior_next;
            filt_reg   <= filt_next;
        end
    end

    // ------------------------------------------------------------------------
    // line buffer with write-to-read forwarding
    // ------------------------------------------------------------------------
    logic  wr_en;
    byte_t val;
    byte_t ram_rdata;

    assign wr_en = s1_move && (s1_kind_reg == KIND_DATA);

    psu_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_prior_row (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_idx_reg),
        .wdata (val),
        .re    (accept),
        .raddr (idx_d),
        .rdata (ram_rdata)
    );

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_DROP;
        end
        else if (src.ready)
        begin
            s1_valid_reg <= src.valid;
            s1_kind_reg  <= kind_d;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_filt_reg  <= filt_reg;
            s1_idx_reg   <= idx_d;
            s1_last_reg  <= last_d;
            s1_prior_reg <= prior_cur;
            s1_raw_reg   <= src.raw_byte;
            byp_hit_reg  <= wr_en && (s1_idx_reg == idx_d);
            byp_data_reg <= val;
        end
    end

    // ------------------------------------------------------------------------
    // reconstruction
    // ------------------------------------------------------------------------
    function automatic logic [9:0] abs10(input logic signed [9:0] x);
        return (x < 0) ? 10'(-x) : 10'(x);
    endfunction

    byte_t            nb_a;
    byte_t            nb_b;
    byte_t            nb_c;
    byte_t            pred;
    logic [8:0]       avg_sum;
    logic [9:0]       dist_a;
    logic [9:0]       dist_b;
    logic [9:0]       dist_c;

    always_comb
    begin
        nb_a = left_hist_reg[pb_idx];
        nb_c = ul_hist_reg[pb_idx];
        if (!s1_prior_reg)
            nb_b = '0;
        else if (byp_hit_reg)
            nb_b = byp_data_reg;
        else
            nb_b = ram_rdata;

        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
        dist_a = abs10(signed'({2'b00, nb_b}) - signed'({2'b00, nb_c}));
        dist_b = abs10(signed'({2'b00, nb_a}) - signed'({2'b00, nb_c}));
        dist_c = abs10(signed'({1'b0, avg_sum}) - signed'({1'b0, nb_c, 1'b0}));

        case (s1_filt_reg)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH:
            begin
                if (dist_a <= dist_b && dist_a <= dist_c)
                    pred = nb_a;
                else if (dist_b <= dist_c)
                    pred = nb_b;
                else
                    pred = nb_c;
            end
            default:    pred = '0;
        endcase

        val = s1_raw_reg + pred;
    end

    // history shift lines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                left_hist_reg[k] <= '0;
                ul_hist_reg[k]   <= '0;
            end
        end
        else if (s1_move)
        begin
            case (s1_kind_reg) inside
                KIND_FILT, KIND_ERR:
                begin
                    for (int k = 0; k < MAX_PIXEL_BYTES; k++)
                    begin
                        left_hist_reg[k] <= '0;
                        ul_hist_reg[k]   <= '0;
                    end
                end
                KIND_DATA:
                begin
                    left_hist_reg[0] <= val;
                    ul_hist_reg[0]   <= nb_b;
                    for (int k = 1; k < MAX_PIXEL_BYTES; k++)
                    begin
                        left_hist_reg[k] <= left_hist_reg[k-1];
                        ul_hist_reg[k]   <= ul_hist_reg[k-1];
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg &&
                             (s1_kind_reg == KIND_DATA || s1_kind_reg == KIND_ERR);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            if (s1_kind_reg == KIND_DATA)
            begin
                out_pixel_reg   <= val;
                out_row_end_reg <= s1_last_reg;
                out_bad_reg     <= 1'b0;
            end
            else
            begin
                out_pixel_reg   <= '0;
                out_row_end_reg <= 1'b0;
                out_bad_reg     <= 1'b1;
            end
        end
    end

    assign dst.valid      = out_valid_reg;
    assign dst.pixel_byte = out_pixel_reg;
    assign dst.row_end    = out_row_end_reg;
    assign dst.bad_filter = out_bad_reg;

endmodule

[tb/tb_png_scanline_unfilter.sv]
// ============================================================================
// tb_png_scanline_unfilter - testbench for the PNG scanline unfilter
// Drives filtered byte streams through the src channel and compares every
// dst item against a cycle-free predictor of the None/Sub/Up/Average/Paeth
// reconstruction. Directed cases first, then the longest rows, then random
// images under four idle/stall mixes with configuration changes in between.
// ============================================================================
module tb_png_scanline_unfilter;

    import psu_pkg::*;

    localparam int       MAX_ROW       = 4096;
    localparam int       MAX_PIX       = 8;
    localparam int       SETTLE_CYCLES = 8;
    localparam int       CYCLE_LIMIT   = 300000;
    localparam int       PHASE_ITEMS   = 230;
    localparam int       LONG_ROW_PART = 80;
    localparam cfg_idx_t REG_SPARE     = cfg_idx_t'(15);

    typedef struct packed {
        byte_t value;
        logic  row_end;
        logic  bad_filter;
    } pixel_res_t;

    logic clk;
    logic rst_n;

    psu_cfg_if cfg_ch ();
    psu_in_if  src_ch ();
    psu_out_if dst_ch ();

    png_scanline_unfilter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .src   (src_ch),
        .dst   (dst_ch)
    );

    // expected reconstructed bytes, oldest first
    pixel_res_t pending_pixels[$];

    // predictor state
    byte_t       above_row [MAX_ROW];
    logic        above_valid;
    int unsigned next_col;
    filt_t       row_filter;
    byte_t       left_hist [MAX_PIX];
    byte_t       diag_hist [MAX_PIX];
    logic        aborted;
    cfg_data_t   row_cfg;
    logic [3:0]  pix_cfg;

    int   fail_count;
    int   data_items;
    int   src_idle_pct;
    int   dst_stall_pct;
    logic reopen_image;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned row_len(input cfg_data_t v);
        if (v == 0)
            return 1;
        if (v > MAX_ROW)
            return MAX_ROW;
        return v;
    endfunction

    function automatic int unsigned pix_len(input logic [3:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_PIX)
            return MAX_PIX;
        return v;
    endfunction

    function automatic int paeth_choice(input int a, input int b, input int c);
        int p;
        int da;
        int db;
        int dc;
        p  = a + b - c;
        da = (p >= a) ? p - a : a - p;
        db = (p >= b) ? p - b : b - p;
        dc = (p >= c) ? p - c : c - p;
        if (da <= db && da <= dc)
            return a;
        return (db <= dc) ? b : c;
    endfunction

    // advance the predictor by one accepted item, queue its result if any
    function automatic void unfilter_byte(input byte_t raw, input logic start);
        pixel_res_t  res;
        int unsigned len;
        int unsigned pb;
        int unsigned idx;
        int          a;
        int          b;
        int          c;
        int          pred;
        byte_t       val;

        if (start)
        begin
            above_valid = 1'b0;
            aborted     = 1'b0;
            next_col    = 0;
        end
        if (aborted)
            return;
        data_items++;

        // filter type byte: clears the neighbor histories
        if (next_col == 0)
        begin
            for (int k = 0; k < MAX_PIX; k++)
            begin
                left_hist[k] = '0;
                diag_hist[k] = '0;
            end
            if (raw > FILT_PAETH)
            begin
                aborted = 1'b1;
                res = '{value: '0, row_end: 1'b0, bad_filter: 1'b1};
                pending_pixels.push_back(res);
                return;
            end
            row_filter = filt_t'(raw);
            next_col   = 1;
            return;
        end

        len = row_len(row_cfg);
        pb  = pix_len(pix_cfg);
        idx = next_col - 1;
        a   = left_hist[pb-1];
        c   = diag_hist[pb-1];
        b   = above_valid ? int'(above_row[idx]) : 0;

        case (row_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) >> 1;
            FILT_PAETH: pred = paeth_choice(a, b, c);
            default:    pred = 0;
        endcase
        val = byte_t'(int'(raw) + pred);

        above_row[idx] = val;
        for (int k = MAX_PIX - 1; k > 0; k--)
        begin
            left_hist[k] = left_hist[k-1];
            diag_hist[k] = diag_hist[k-1];
        end
        left_hist[0] = val;
        diag_hist[0] = byte_t'(b);

        res = '{value: val, row_end: (idx + 1 >= len), bad_filter: 1'b0};
        if (idx + 1 >= len)
        begin
            next_col    = 0;
            above_valid = 1'b1;
        end
        else
        begin
            next_col++;
        end
        pending_pixels.push_back(res);
    endfunction

    // dst side: check each item, then pick next ready
    initial
    begin
        pixel_res_t got;
        pixel_res_t want;
        dst_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dst_ch.valid && dst_ch.ready)
            begin
                got = '{value: dst_ch.pixel_byte, row_end: dst_ch.row_end,
                        bad_filter: dst_ch.bad_filter};
                if (pending_pixels.size() == 0)
                begin
                    $display({"%0t: unexpected item: expected none,",
                              " got pixel=%02h row_end=%0b bad=%0b"},
                             $time, got.value, got.row_end, got.bad_filter);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.value !== want.value || got.row_end !== want.row_end ||
                        got.bad_filter !== want.bad_filter)
                    begin
                        $display({"%0t: mismatch: expected pixel=%02h row_end=%0b bad=%0b,",
                                  " got pixel=%02h row_end=%0b bad=%0b"},
                                 $time, want.value, want.row_end, want.bad_filter,
                                 got.value, got.row_end, got.bad_filter);
                        fail_count++;
                    end
                end
            end
            dst_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // send one item, with a random gap before it
    task automatic push_byte(input byte_t raw, input logic start);
        logic first;
        first        = start | reopen_image;
        reopen_image = 1'b0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid       <= 1'b1;
        src_ch.raw_byte    <= raw;
        src_ch.image_start <= first;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
        unfilter_byte(raw, first);
    endtask

    // hold the sender until every expected item has come out
    task automatic wait_for_results;
        src_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // also covers filter bytes still in flight, which give no item
    task automatic settle_block;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // a longer row would read line buffer entries never written: restart image
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_ROW_BYTES)
        begin
            if (row_len(val) > row_len(row_cfg))
                reopen_image = 1'b1;
            row_cfg = val;
        end
        else if (idx == REG_PIXEL_BYTES)
        begin
            pix_cfg = val[3:0];
        end
        @(posedge clk);
    endtask

    // data byte mix: full range, corner values, small values
    function automatic byte_t random_data();
        case ($urandom_range(3)) inside
            0, 1:    return byte_t'($urandom_range(255));
            2:       return byte_t'(($urandom_range(1) != 0) ? 8'hFF : 8'h00) ^
                            byte_t'($urandom_range(1));
            default: return byte_t'($urandom_range(8));
        endcase
    endfunction

    // one image of whole rows; now and then a bad filter or a stray restart
    task automatic send_image(input int rows);
        int unsigned len;
        for (int r = 0; r < rows; r++)
        begin
            len = row_len(row_cfg);
            if ($urandom_range(99) < 3)
            begin
                push_byte(byte_t'($urandom_range(255, 5)), r == 0);
                repeat ($urandom_range(6))
                    push_byte(byte_t'($urandom), 1'b0);
                return;
            end
            push_byte(byte_t'($urandom_range(4)), r == 0);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 2)
                    wait_for_results();
                if ($urandom_range(199) == 0)
                    push_byte(byte_t'($urandom), 1'b1);
                else
                    push_byte(random_data(), 1'b0);
            end
        end
    endtask

    // reset values: one-byte rows, one-byte pixels; no image start needed
    task automatic test_power_up_defaults;
        push_byte(byte_t'(FILT_NONE), 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(byte_t'(FILT_SUB), 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(byte_t'(FILT_UP), 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(byte_t'(FILT_AVG), 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(byte_t'(FILT_PAETH), 1'b0);
        push_byte(8'h7F, 1'b0);
        settle_block();
    endtask

    // unknown filter codes, dropping until the next image start
    task automatic test_bad_filter;
        push_byte(8'd5, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(byte_t'(FILT_NONE), 1'b1);
        push_byte(8'h33, 1'b0);
        push_byte(8'd7, 1'b0);
        push_byte(8'h44, 1'b0);
        settle_block();
    endtask

    // pixel size above 8, then zero row and pixel sizes
    task automatic test_size_extremes;
        write_reg(REG_ROW_BYTES, cfg_data_t'(9));
        write_reg(REG_PIXEL_BYTES, cfg_data_t'(15));
        push_byte(byte_t'(FILT_SUB), 1'b1);
        repeat (9) push_byte(8'h01, 1'b0);
        push_byte(byte_t'(FILT_PAETH), 1'b0);
        repeat (9) push_byte(8'hFF, 1'b0);
        settle_block();
        write_reg(REG_ROW_BYTES, cfg_data_t'(0));
        write_reg(REG_PIXEL_BYTES, 13'h1FF0);
        push_byte(byte_t'(FILT_AVG), 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(byte_t'(FILT_UP), 1'b0);
        push_byte(8'hAA, 1'b0);
        settle_block();
    endtask

    // row length cut below the current column ends the row at once
    task automatic test_row_shrink;
        write_reg(REG_ROW_BYTES, cfg_data_t'(6));
        write_reg(REG_PIXEL_BYTES, cfg_data_t'(2));
        push_byte(byte_t'(FILT_NONE), 1'b1);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        settle_block();
        write_reg(REG_ROW_BYTES, cfg_data_t'(2));
        push_byte(8'h40, 1'b0);
        push_byte(byte_t'(FILT_UP), 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(byte_t'(FILT_PAETH), 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        settle_block();
    endtask

    // writes to an unused register index change nothing
    task automatic test_spare_register;
        write_reg(REG_SPARE, 13'h1FFF);
        push_byte(byte_t'(FILT_SUB), 1'b1);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b0);
        settle_block();
    endtask

    // row length at and above the maximum: the start of a row never ends early
    task automatic test_longest_rows;
        write_reg(REG_ROW_BYTES, cfg_data_t'(MAX_ROW));
        write_reg(REG_PIXEL_BYTES, cfg_data_t'(3));
        push_byte(byte_t'(FILT_NONE), 1'b1);
        repeat (LONG_ROW_PART) push_byte(random_data(), 1'b0);
        settle_block();
        write_reg(REG_ROW_BYTES, 13'h1FFF);
        write_reg(REG_PIXEL_BYTES, cfg_data_t'(MAX_PIX));
        push_byte(byte_t'(FILT_SUB), 1'b1);
        repeat (LONG_ROW_PART) push_byte(random_data(), 1'b0);
        settle_block();
        write_reg(REG_ROW_BYTES, cfg_data_t'(16));
    endtask

    // random images under each idle/stall mix, new sizes between images
    task automatic test_random_traffic;
        int          first_item;
        int          pick;
        int unsigned len;
        logic [3:0]  pix;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1:       begin src_idle_pct = 57; dst_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  dst_stall_pct = 57; end
                default: begin src_idle_pct = 34; dst_stall_pct = 34; end
            endcase
            first_item = data_items;
            while (data_items - first_item < PHASE_ITEMS)
            begin
                settle_block();
                pick = $urandom_range(99);
                if (pick < 5)
                    write_reg(REG_ROW_BYTES, cfg_data_t'(0));
                else if (pick < 10)
                    write_reg(REG_ROW_BYTES, cfg_data_t'($urandom_range(300, 100)));
                else if (pick < 80)
                    write_reg(REG_ROW_BYTES, cfg_data_t'($urandom_range(16, 1)));
                if ($urandom_range(1) != 0)
                    pix = 4'($urandom_range(15));
                else
                    pix = 4'($urandom_range(4, 1));
                write_reg(REG_PIXEL_BYTES, {9'($urandom), pix});
                len = row_len(row_cfg);
                repeat ($urandom_range(3, 1))
                    send_image((len > 64) ? 1 : $urandom_range(5, 1));
            end
        end
        src_idle_pct  = 0;
        dst_stall_pct = 0;
    endtask

    // stimulus
    initial
    begin
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        src_ch.valid       <= 1'b0;
        src_ch.raw_byte    <= '0;
        src_ch.image_start <= 1'b0;

        // predictor reset state
        above_valid   = 1'b0;
        next_col      = 0;
        row_filter    = FILT_NONE;
        aborted       = 1'b0;
        row_cfg       = ROW_BYTES_RST;
        pix_cfg       = PIXEL_BYTES_RST;
        fail_count    = 0;
        data_items    = 0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        reopen_image  = 1'b0;
        for (int k = 0; k < MAX_PIX; k++)
        begin
            left_hist[k] = '0;
            diag_hist[k] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_defaults();
        test_bad_filter();
        test_size_extremes();
        test_row_shrink();
        test_spare_register();
        test_longest_rows();
        test_random_traffic();

        settle_block();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
